// File: sv/etr_pkg.sv
`timescale 1ns / 1ps
package etr_pkg;

  localparam int COORD_BITS   = 16;
  localparam int CORDIC_STEPS = 30;
  localparam int CORDIC_K     = 652032874;
  // Width of the sine/cosine datapath, including its angle accumulator.
  localparam int VEC_W        = 34;
  localparam int ANG_W        = 35;
  localparam int ATAN_IN_W    = 33;
  localparam int PADDR_W      = 3;
  localparam int REG_TILT     = 0;

  // atan(2^-i) on the scale where 2^31 is pi.
  function automatic logic [29:0] atan_tab(input logic [4:0] idx);
    logic [29:0] t;
    case (idx)
      5'd0:    t = 30'd536870912;
      5'd1:    t = 30'd316933406;
      5'd2:    t = 30'd167458907;
      5'd3:    t = 30'd85004756;
      5'd4:    t = 30'd42667331;
      5'd5:    t = 30'd21354465;
      5'd6:    t = 30'd10679838;
      5'd7:    t = 30'd5340245;
      5'd8:    t = 30'd2670163;
      5'd9:    t = 30'd1335087;
      5'd10:   t = 30'd667544;
      5'd11:   t = 30'd333772;
      5'd12:   t = 30'd166886;
      5'd13:   t = 30'd83443;
      5'd14:   t = 30'd41722;
      5'd15:   t = 30'd20861;
      5'd16:   t = 30'd10430;
      5'd17:   t = 30'd5215;
      5'd18:   t = 30'd2608;
      5'd19:   t = 30'd1304;
      5'd20:   t = 30'd652;
      5'd21:   t = 30'd326;
      5'd22:   t = 30'd163;
      5'd23:   t = 30'd81;
      5'd24:   t = 30'd41;
      5'd25:   t = 30'd20;
      5'd26:   t = 30'd10;
      5'd27:   t = 30'd5;
      5'd28:   t = 30'd3;
      5'd29:   t = 30'd1;
      default: t = 30'd0;
    endcase
    return t;
  endfunction

endpackage

// File: sv/equirect_tilt_remap.sv
`timescale 1ns / 1ps
// Remaps one equirectangular destination coordinate per clock to its source
// coordinate under a tilt about the x axis. The pipeline consists of two
// 30-step CORDIC units in series (sine/cosine, then arctangent), two 31-step
// square root units and eight single-register arithmetic stages.
// A new item can enter in every cycle. The whole pipeline holds while a result
// waits on a stalled output, so the input stalls only then.
// The tilt register is written through the APB port at byte address 0.
module equirect_tilt_remap #(
  parameter int CoordBits = etr_pkg::COORD_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [CoordBits-1:0]   lon_in_i,
  input  logic signed [CoordBits-1:0]   lat_in_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [CoordBits-1:0]   lon_out_o,
  output logic signed [CoordBits-1:0]   lat_out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [etr_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int VW   = etr_pkg::VEC_W;
  localparam int AW   = etr_pkg::ANG_W;
  localparam int IW   = etr_pkg::ATAN_IN_W;
  localparam int Sq1W = 61;
  localparam int Sq2W = 62;
  localparam int Sq1N = (Sq1W + 1) / 2;
  localparam int Sq2N = (Sq2W + 1) / 2;
  localparam int Lat  = 3 * etr_pkg::CORDIC_STEPS - etr_pkg::CORDIC_STEPS + Sq1N + Sq2N + 8;
  localparam int Sh   = 32 - CoordBits;
  localparam logic signed [63:0] Half = 64'sd536870912;
  localparam logic [63:0] OneQ60 = 64'h1000_0000_0000_0000;
  localparam logic signed [AW:0] Rnd = (AW+1)'((64'sd1 <<< Sh) >>> 1);
  localparam logic signed [AW:0] Hi  = (AW+1)'((64'sd1 <<< (CoordBits - 1)) - 64'sd1);
  localparam logic signed [AW:0] Lo  = -Hi - (AW+1)'(1);

  logic                        en;
  logic [Lat-1:0]              vld_q;
  logic signed [CoordBits-1:0] tilt_q;
  logic                        reg_sel;

  // Configuration port.
  assign pready  = 1'b1;
  assign reg_sel = paddr[etr_pkg::PADDR_W-1:2] == 1'(etr_pkg::REG_TILT);
  assign prdata  = reg_sel ? 32'(tilt_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tilt_q <= '0;
    end else if (psel && penable && pwrite && reg_sel) begin
      tilt_q <= pwdata[CoordBits-1:0];
    end
  end

  // The pipeline moves as one; it holds only while a result waits.
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Lat-2:0], in_valid_i};
    end
  end
  assign out_valid_o = vld_q[Lat-1];

  // Sines and cosines of both coordinates and of the tilt.
  logic signed [VW-1:0] cp, sp, ct, st, ca, sa;

  etr_sincos #(.CoordBits(CoordBits)) u_sc_lon (
    .clk_i(clk_i), .en_i(en), .angle_i(lon_in_i), .cos_o(cp), .sin_o(sp)
  );
  etr_sincos #(.CoordBits(CoordBits)) u_sc_lat (
    .clk_i(clk_i), .en_i(en), .angle_i(lat_in_i), .cos_o(ct), .sin_o(st)
  );
  etr_sincos #(.CoordBits(CoordBits)) u_sc_tilt (
    .clk_i(clk_i), .en_i(en), .angle_i(tilt_q), .cos_o(ca), .sin_o(sa)
  );

  // Unit vector.
  logic signed [63:0] pxc, pyc;
  logic signed [31:0] x_a_q, y_a_q, z_a_q, ca_a_q, sa_a_q;
  assign pxc = 64'(32'(ct)) * 64'(32'(cp)) + Half;
  assign pyc = 64'(32'(ct)) * 64'(32'(sp)) + Half;

  always_ff @(posedge clk_i) begin
    if (en) begin
      x_a_q  <= 32'(pxc >>> 30);
      y_a_q  <= 32'(pyc >>> 30);
      z_a_q  <= 32'(st);
      ca_a_q <= 32'(ca);
      sa_a_q <= 32'(sa);
    end
  end

  // Rotation about x.
  logic signed [63:0] p1_b_q, p2_b_q, p3_b_q, p4_b_q;
  logic signed [31:0] x_b_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_b_q <= 64'(y_a_q) * 64'(ca_a_q);
      p2_b_q <= 64'(z_a_q) * 64'(sa_a_q);
      p3_b_q <= 64'(y_a_q) * 64'(sa_a_q);
      p4_b_q <= 64'(z_a_q) * 64'(ca_a_q);
      x_b_q  <= x_a_q;
    end
  end

  logic signed [65:0] sum_y1, sum_z1;
  logic signed [31:0] z1_c_q, x_c_q;
  logic               neg_c_q;
  assign sum_y1 = 66'(p1_b_q) + 66'(p2_b_q) + 66'(Half);
  assign sum_z1 = 66'(p4_b_q) - 66'(p3_b_q) + 66'(Half);

  always_ff @(posedge clk_i) begin
    if (en) begin
      neg_c_q <= sum_y1[65];
      z1_c_q  <= 32'(sum_z1 >>> 30);
      x_c_q   <= x_b_q;
    end
  end

  logic [63:0]        z1sq_d_q;
  logic signed [31:0] z1_d_q, x_d_q;
  logic               neg_d_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      z1sq_d_q <= 64'(64'(z1_c_q) * 64'(z1_c_q));
      z1_d_q   <= z1_c_q;
      x_d_q    <= x_c_q;
      neg_d_q  <= neg_c_q;
    end
  end

  logic [Sq1W-1:0]    v_e_q;
  logic signed [31:0] z1_e_q, x_e_q;
  logic               neg_e_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      v_e_q   <= (z1sq_d_q >= OneQ60) ? '0 : Sq1W'(OneQ60 - z1sq_d_q);
      z1_e_q  <= z1_d_q;
      x_e_q   <= x_d_q;
      neg_e_q <= neg_d_q;
    end
  end

  // Radius in the xy plane.
  logic [Sq1N-1:0]    r_s;
  logic [64:0]        side1_in, side1_out;
  assign side1_in = {neg_e_q, x_e_q, z1_e_q};

  etr_isqrt #(.InW(Sq1W), .SideW(65)) u_sqrt_r (
    .clk_i(clk_i), .en_i(en), .val_i(v_e_q), .side_i(side1_in),
    .root_o(r_s), .side_o(side1_out)
  );

  logic signed [31:0] x_s, z1_s;
  logic               neg_s;
  assign {neg_s, x_s, z1_s} = side1_out;

  logic [Sq1N-1:0]    r_f_q;
  logic [Sq2W-1:0]    rsq_f_q;
  logic [63:0]        xsq_f_q;
  logic signed [31:0] x_f_q, z1_f_q;
  logic               neg_f_q, zero_f_q;
  logic signed [32:0] rs, xs;
  assign rs = {2'b00, r_s};
  assign xs = 33'(x_s);

  always_ff @(posedge clk_i) begin
    if (en) begin
      r_f_q    <= r_s;
      rsq_f_q  <= Sq2W'(64'(r_s) * 64'(r_s));
      xsq_f_q  <= 64'(64'(x_s) * 64'(x_s));
      zero_f_q <= (r_s == '0) || (xs > rs) || (xs < -rs);
      x_f_q    <= x_s;
      z1_f_q   <= z1_s;
      neg_f_q  <= neg_s;
    end
  end

  logic [Sq2W-1:0]    d_g_q;
  logic [Sq1N-1:0]    r_g_q;
  logic signed [31:0] x_g_q, z1_g_q;
  logic               neg_g_q, zero_g_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      d_g_q    <= zero_f_q ? '0 : Sq2W'(64'(rsq_f_q) - xsq_f_q);
      r_g_q    <= r_f_q;
      x_g_q    <= x_f_q;
      z1_g_q   <= z1_f_q;
      neg_g_q  <= neg_f_q;
      zero_g_q <= zero_f_q;
    end
  end

  // Opposite side for the arccosine.
  logic [Sq2N-1:0]        s_s;
  logic [Sq1N+65:0]       side2_in, side2_out;
  assign side2_in = {zero_g_q, neg_g_q, r_g_q, x_g_q, z1_g_q};

  etr_isqrt #(.InW(Sq2W), .SideW(Sq1N + 66)) u_sqrt_s (
    .clk_i(clk_i), .en_i(en), .val_i(d_g_q), .side_i(side2_in),
    .root_o(s_s), .side_o(side2_out)
  );

  logic               zero_h, neg_h;
  logic [Sq1N-1:0]    r_h;
  logic signed [31:0] x_h, z1_h;
  assign {zero_h, neg_h, r_h, x_h, z1_h} = side2_out;

  logic signed [AW-1:0] lon_ang, lat_ang;
  logic                 zero_o, neg_o;

  etr_atan2 #(.SideW(1)) u_atan_lon (
    .clk_i(clk_i), .en_i(en), .y_i(IW'({1'b0, s_s})), .x_i(IW'(x_h)),
    .side_i(zero_h), .ang_o(lon_ang), .side_o(zero_o)
  );
  etr_atan2 #(.SideW(1)) u_atan_lat (
    .clk_i(clk_i), .en_i(en), .y_i(IW'(z1_h)), .x_i(IW'({1'b0, r_h})),
    .side_i(neg_h), .ang_o(lat_ang), .side_o(neg_o)
  );

  // Round to the output scale and saturate.
  function automatic logic [CoordBits-1:0] to_out(input logic signed [AW-1:0] a);
    logic signed [AW:0] v;
    v = ((AW+1)'(a) + Rnd) >>> Sh;
    if (v > Hi) begin
      v = Hi;
    end else if (v < Lo) begin
      v = Lo;
    end
    return v[CoordBits-1:0];
  endfunction

  logic signed [AW-1:0] lon_fin;
  always_comb begin
    lon_fin = zero_o ? '0 : lon_ang;
    if (neg_o) begin
      lon_fin = -lon_fin;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      lon_out_o <= to_out(lon_fin);
      lat_out_o <= to_out(lat_ang);
    end
  end

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> vld_q[0])
    else $error("accepted transfer did not enter the pipeline");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a waiting result");

  a_hold_valids: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipeline valid bits moved during a hold");

endmodule

// File: sv/etr_sincos.sv
`timescale 1ns / 1ps
module etr_sincos #(
  parameter int CoordBits = etr_pkg::COORD_BITS
) (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic signed [CoordBits-1:0]         angle_i,
  output logic signed [etr_pkg::VEC_W-1:0]    cos_o,
  output logic signed [etr_pkg::VEC_W-1:0]    sin_o
);

  localparam int N = etr_pkg::CORDIC_STEPS;
  localparam int W = etr_pkg::VEC_W;

  logic [31:0]         ph;
  logic [31:0]         ph_rot;
  logic                flip;
  logic signed [W-1:0] xi [N];
  logic signed [W-1:0] yi [N];
  logic signed [W-1:0] ai [N];
  logic                fi [N];
  logic signed [W-1:0] x_q [N];
  logic signed [W-1:0] y_q [N];
  logic signed [W-1:0] a_q [N];
  logic                f_q [N];

  // Phases in the left half plane are turned by pi and the result negated.
  assign ph     = 32'(angle_i) << (32 - CoordBits);
  assign flip   = ph[31] ^ ph[30];
  assign ph_rot = flip ? (ph + 32'h8000_0000) : ph;

  always_comb begin
    xi[0] = W'(etr_pkg::CORDIC_K);
    yi[0] = '0;
    ai[0] = W'($signed(ph_rot));
    fi[0] = flip;
    for (int k = 1; k < N; k++) begin
      xi[k] = x_q[k-1];
      yi[k] = y_q[k-1];
      ai[k] = a_q[k-1];
      fi[k] = f_q[k-1];
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_step
    logic signed [W-1:0] t;
    assign t = W'(etr_pkg::atan_tab(5'(k)));
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (ai[k] >= 0) begin
          x_q[k] <= xi[k] - (yi[k] >>> k);
          y_q[k] <= yi[k] + (xi[k] >>> k);
          a_q[k] <= ai[k] - t;
        end else begin
          x_q[k] <= xi[k] + (yi[k] >>> k);
          y_q[k] <= yi[k] - (xi[k] >>> k);
          a_q[k] <= ai[k] + t;
        end
        f_q[k] <= fi[k];
      end
    end
  end

  assign cos_o = f_q[N-1] ? -x_q[N-1] : x_q[N-1];
  assign sin_o = f_q[N-1] ? -y_q[N-1] : y_q[N-1];

endmodule

// File: sv/etr_isqrt.sv
`timescale 1ns / 1ps
module etr_isqrt #(
  parameter int InW   = 61,
  parameter int SideW = 1
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [InW-1:0]           val_i,
  input  logic [SideW-1:0]         side_i,
  output logic [(InW+1)/2-1:0]     root_o,
  output logic [SideW-1:0]         side_o
);

  localparam int NS = (InW + 1) / 2;
  localparam int RW = InW + 1;

  logic [InW-1:0]   vi [NS];
  logic [RW-1:0]    ri [NS];
  logic [SideW-1:0] si [NS];
  logic [InW-1:0]   v_q [NS];
  logic [RW-1:0]    r_q [NS];
  logic [SideW-1:0] s_q [NS];

  always_comb begin
    vi[0] = val_i;
    ri[0] = '0;
    si[0] = side_i;
    for (int k = 1; k < NS; k++) begin
      vi[k] = v_q[k-1];
      ri[k] = r_q[k-1];
      si[k] = s_q[k-1];
    end
  end

  // One result bit per stage, highest first.
  for (genvar k = 0; k < NS; k++) begin : g_step
    logic [RW-1:0] bitv;
    logic [RW-1:0] trial;
    assign bitv  = RW'(1) << (2 * (NS - 1 - k));
    assign trial = ri[k] + bitv;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if ({1'b0, vi[k]} >= trial) begin
          v_q[k] <= InW'({1'b0, vi[k]} - trial);
          r_q[k] <= (ri[k] >> 1) + bitv;
        end else begin
          v_q[k] <= vi[k];
          r_q[k] <= ri[k] >> 1;
        end
        s_q[k] <= si[k];
      end
    end
  end

  assign root_o = r_q[NS-1][NS-1:0];
  assign side_o = s_q[NS-1];

endmodule

// File: sv/etr_atan2.sv
`timescale 1ns / 1ps
module etr_atan2 #(
  parameter int SideW = 1
) (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic signed [etr_pkg::ATAN_IN_W-1:0] y_i,
  input  logic signed [etr_pkg::ATAN_IN_W-1:0] x_i,
  input  logic [SideW-1:0]                    side_i,
  output logic signed [etr_pkg::ANG_W-1:0]    ang_o,
  output logic [SideW-1:0]                    side_o
);

  localparam int N  = etr_pkg::CORDIC_STEPS;
  localparam int W  = etr_pkg::ATAN_IN_W + 3;
  localparam int AW = etr_pkg::ANG_W;
  localparam logic signed [AW-1:0] PhasePi = AW'(64'sd2147483648);

  logic signed [W-1:0]  xe, ye;
  logic                 neg;
  logic signed [W-1:0]  xi [N];
  logic signed [W-1:0]  yi [N];
  logic signed [AW-1:0] ai [N];
  logic [SideW-1:0]     si [N];
  logic signed [W-1:0]  x_q [N];
  logic signed [W-1:0]  y_q [N];
  logic signed [AW-1:0] a_q [N];
  logic [SideW-1:0]     s_q [N];

  assign xe  = W'(x_i);
  assign ye  = W'(y_i);
  assign neg = x_i < 0;

  // A vector in the left half plane is mirrored and starts from plus or minus pi.
  always_comb begin
    xi[0] = neg ? -xe : xe;
    yi[0] = neg ? -ye : ye;
    ai[0] = neg ? ((y_i >= 0) ? PhasePi : -PhasePi) : '0;
    si[0] = side_i;
    for (int k = 1; k < N; k++) begin
      xi[k] = x_q[k-1];
      yi[k] = y_q[k-1];
      ai[k] = a_q[k-1];
      si[k] = s_q[k-1];
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_step
    logic signed [AW-1:0] t;
    assign t = AW'(etr_pkg::atan_tab(5'(k)));
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (yi[k] > 0) begin
          x_q[k] <= xi[k] + (yi[k] >>> k);
          y_q[k] <= yi[k] - (xi[k] >>> k);
          a_q[k] <= ai[k] + t;
        end else begin
          x_q[k] <= xi[k] - (yi[k] >>> k);
          y_q[k] <= yi[k] + (xi[k] >>> k);
          a_q[k] <= ai[k] - t;
        end
        s_q[k] <= si[k];
      end
    end
  end

  assign ang_o  = a_q[N-1];
  assign side_o = s_q[N-1];

endmodule
